/* sv/mio_pkg.sv */
// Package for the max interval overlap load block.
// Holds the item structs, the chain token and the field widths.
// No dependencies.
`default_nettype none

package mio_pkg;

  localparam int unsigned MAX_JOBS_DEF = 64;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned JLOAD_W      = 16;
  localparam int unsigned SUM_W        = 22;
  localparam int unsigned JCNT_W       = 7;
  localparam int unsigned JCNT_SAT     = 127;

  typedef struct packed {
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic [JLOAD_W-1:0] job_load;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]  max_load;
    logic              overflow;
    logic [JCNT_W-1:0] job_count;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic [JLOAD_W-1:0] job_load;
  } job_t;

  // probe time travelling down the chain with its running sum
  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] t;
    logic [SUM_W-1:0]  sum;
  } tok_t;

  typedef struct packed {
    logic shift;  // load a new job at the head
    logic run;    // move probe times back toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/max_interval_overlap_load.sv */
// Top level of the max interval overlap load block: control and the cell chain.
// Depends on mio_pkg and mio_cell.
//
// Usage: jobs arrive on the input channel (in_valid_i / in_stall_o), one per
// cycle while loading. Each job is shifted into the head of a chain of
// MAX_JOBS cells; jobs past capacity are dropped and flagged. The item with
// last set closes the set and starts a pass: each stored start time is sent
// down the chain as a probe, one per cycle, and every cell adds its load when
// its job is active at that time. The result item appears on the output
// channel (out_valid_o / out_stall_i) once the last probe has left the end of
// the chain and its sum has been taken into the running maximum.
// Input is stalled during the pass; loading of the next set resumes right
// after, also while the result still waits in the output register. A pass
// that ends while that register is still held waits for it to drain.
// Reset empties the set and clears the output valid.
`default_nettype none

module max_interval_overlap_load import mio_pkg::*; #(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             dropped_q, dropped_d;
  logic [CNT_W-1:0] inj_q, inj_d;
  logic [CNT_W-1:0] exit_q, exit_d;
  logic [SUM_W-1:0] best_q, best_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             in_acc, has_room, done, out_free;
  logic [31:0]      cnt_ext;
  cell_ctrl_t       ctrl;

  job_t              job_c  [MAX_JOBS+1];
  logic [TIME_W-1:0] tsrc_c [MAX_JOBS+1];
  tok_t              tok_c  [MAX_JOBS+1];

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign has_room   = (count_q < CNT_W'(MAX_JOBS));
  assign done       = (state_q == ST_RUN) && (exit_q == count_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_ext    = 32'(count_q);

  assign ctrl.shift = in_acc && has_room;
  assign ctrl.run   = (state_q == ST_RUN);

  assign job_c[0].start_time = in_item_i.start_time;
  assign job_c[0].end_time   = in_item_i.end_time;
  assign job_c[0].job_load   = in_item_i.job_load;
  assign tsrc_c[MAX_JOBS]    = '0;

  assign tok_c[0].vld = (state_q == ST_RUN) && (inj_q < count_q);
  assign tok_c[0].t   = tsrc_c[0];
  assign tok_c[0].sum = '0;

  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
    mio_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .active_i (count_q > CNT_W'(k)),
      .job_i    (job_c[k]),
      .job_o    (job_c[k+1]),
      .tsrc_i   (tsrc_c[k+1]),
      .tsrc_o   (tsrc_c[k]),
      .tok_i    (tok_c[k]),
      .tok_o    (tok_c[k+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    inj_d       = inj_q;
    exit_d      = exit_q;
    best_d      = best_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_item_i.last) begin
            state_d = ST_RUN;
            inj_d   = '0;
            exit_d  = '0;
            best_d  = '0;
          end
        end
      end
      ST_RUN: begin
        if (tok_c[0].vld) begin
          inj_d = inj_q + 1'b1;
        end
        if (tok_c[MAX_JOBS].vld) begin
          exit_d = exit_q + 1'b1;
          if (tok_c[MAX_JOBS].sum > best_q) begin
            best_d = tok_c[MAX_JOBS].sum;
          end
        end
        if (done && out_free) begin
          out_valid_d     = 1'b1;
          out_d.max_load  = best_q;
          out_d.overflow  = dropped_q;
          out_d.job_count = (cnt_ext > 32'(JCNT_SAT)) ? JCNT_W'(JCNT_SAT)
                                                       : cnt_ext[JCNT_W-1:0];
          count_d         = '0;
          dropped_d       = 1'b0;
          state_d         = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      inj_q       <= '0;
      exit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      inj_q       <= inj_d;
      exit_q      <= exit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_JOBS))
    else $error("job count beyond capacity");

  a_exit_le_inj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (exit_q <= inj_q) && (inj_q <= count_q))
    else $error("probe counters out of order");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && out_free) |=> (out_valid_o && state_q == ST_LOAD && count_q == '0))
    else $error("pass end did not publish result and empty the set");

endmodule

`default_nettype wire

/* sv/mio_cell.sv */
// One cell of the overlap chain: holds one job and adds its load to passing probes.
// Depends on mio_pkg.
`default_nettype none

module mio_cell import mio_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              active_i,
  input  job_t              job_i,
  output job_t              job_o,
  input  logic [TIME_W-1:0] tsrc_i,
  output logic [TIME_W-1:0] tsrc_o,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  job_t              job_q;
  logic [TIME_W-1:0] tsrc_q;
  tok_t              tok_q, tok_d;
  logic              hit;
  logic [SUM_W:0]    sum_wide;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      tsrc_q <= job_i.start_time;
    end else if (ctrl_i.run) begin
      tsrc_q <= tsrc_i;
    end
  end

  // end before start counts as end equal to start
  assign hit = active_i && tok_i.vld && (job_q.start_time <= tok_i.t) &&
               ((job_q.end_time >= tok_i.t) || (job_q.start_time == tok_i.t));

  assign sum_wide = {1'b0, tok_i.sum} + (SUM_W+1)'(job_q.job_load);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.sum = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign job_o  = job_q;
  assign tsrc_o = tsrc_q;
  assign tok_o  = tok_q;

endmodule

`default_nettype wire

/* test/mio_result_check.sv */
`timescale 1ns / 100ps
// Result checker for max_interval_overlap_load: watches both channels, keeps its
// own job set, predicts each result and compares it field by field. Depends on mio_pkg.

module mio_result_check import mio_pkg::*; #(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  input  logic        drain_done_i,
  output int unsigned fail_cnt_o,
  output int unsigned res_cnt_o
);

  localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 1;

  job_t        job_set [MAX_JOBS];
  int unsigned jobs_held;
  logic        set_dropped;
  out_item_t   owed_results [$];
  int unsigned errs;
  int unsigned results_seen;
  logic        drain_seen;

  function automatic logic [SUM_W-1:0] peak_concurrent_load();
    longint unsigned   best;
    longint unsigned   sum;
    logic [TIME_W-1:0] probe;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    int unsigned       i;
    int unsigned       j;
    best = 0;
    for (i = 0; i < jobs_held; i++) begin
      probe = job_set[i].start_time;
      sum = 0;
      for (j = 0; j < jobs_held; j++) begin
        s = job_set[j].start_time;
        e = job_set[j].end_time;
        if (e < s) e = s;
        if (s <= probe && e >= probe) sum += 64'(job_set[j].job_load);
      end
      if (sum > SUM_SAT) sum = SUM_SAT;
      if (sum > best) best = sum;
    end
    return best[SUM_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t   want;
    int unsigned cnt;
    if (!rst_ni) begin
      jobs_held    = 0;
      set_dropped  = 1'b0;
      errs         = 0;
      results_seen = 0;
      drain_seen   = 1'b0;
      owed_results.delete();
      fail_cnt_o <= 0;
      res_cnt_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected item: max_load %0d overflow %0b job_count %0d", $time,
                   out_item_i.max_load, out_item_i.overflow, out_item_i.job_count);
          errs++;
        end else begin
          want = owed_results.pop_front();
          if (out_item_i.max_load !== want.max_load) begin
            $display("%0t: max_load expected %0d actual %0d", $time,
                     want.max_load, out_item_i.max_load);
            errs++;
          end
          if (out_item_i.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time,
                     want.overflow, out_item_i.overflow);
            errs++;
          end
          if (out_item_i.job_count !== want.job_count) begin
            $display("%0t: job_count expected %0d actual %0d", $time,
                     want.job_count, out_item_i.job_count);
            errs++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (jobs_held < MAX_JOBS) begin
          job_set[jobs_held].start_time = in_item_i.start_time;
          job_set[jobs_held].end_time   = in_item_i.end_time;
          job_set[jobs_held].job_load   = in_item_i.job_load;
          jobs_held++;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_item_i.last) begin
          cnt = (jobs_held > JCNT_SAT) ? JCNT_SAT : jobs_held;
          want.max_load  = peak_concurrent_load();
          want.overflow  = set_dropped;
          want.job_count = cnt[JCNT_W-1:0];
          owed_results.push_back(want);
          jobs_held   = 0;
          set_dropped = 1'b0;
        end
      end

      if (drain_done_i && !drain_seen) begin
        drain_seen = 1'b1;
        if (owed_results.size() != 0) begin
          $display("%0t: %0d expected items never arrived", $time, owed_results.size());
          errs += owed_results.size();
        end
      end

      fail_cnt_o <= errs;
      res_cnt_o  <= results_seen;
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for max_interval_overlap_load: clock, reset, job stimulus, output
// stalls, watchdog and verdict. Depends on mio_pkg, the block and mio_result_check.

module tb_top;
  import mio_pkg::*;

  localparam int unsigned N_JOBS     = MAX_JOBS_DEF;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned ITEM_GOAL  = 800;
  localparam int unsigned SET_GOAL   = 40;

  typedef enum int unsigned {
    SET_PEAK,
    SET_FULL,
    SET_OVER,
    SET_NOISE,
    SET_SHAPED
  } set_kind_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        drain_done;
  int unsigned fail_cnt;
  int unsigned res_cnt;
  int unsigned sets_sent;
  int unsigned items_sent;
  int unsigned idle_cycles;
  logic        long_hold_done;

  max_interval_overlap_load #(
    .MAX_JOBS(N_JOBS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  mio_result_check #(
    .MAX_JOBS(N_JOBS)
  ) overlap_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .drain_done_i(drain_done),
    .fail_cnt_o  (fail_cnt),
    .res_cnt_o   (res_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_job(input logic [15:0] s, input logic [15:0] e,
                          input logic [15:0] w, input logic fin);
    in_item_t    it;
    int unsigned r;
    int unsigned gap;
    it.start_time = s;
    it.end_time   = e;
    it.job_load   = w;
    it.last       = fin;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (fin) sets_sent++;
    r = $urandom_range(99);
    if (r < 70) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (res_cnt != sets_sent) @(posedge clk);
  endtask

  task automatic send_set(input set_kind_e kind, input int unsigned n);
    logic [15:0] base;
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] w;
    int unsigned k;
    base = 16'($urandom_range(0, 65535));
    for (k = 0; k < n; k++) begin
      case (kind)
        SET_PEAK: begin
          s = 16'($urandom_range(0, 3));
          e = 16'hFFFF;
          w = 16'hFFFF;
        end
        SET_NOISE: begin
          s = 16'($urandom_range(0, 65535));
          e = 16'($urandom_range(0, 65535));
          w = 16'($urandom_range(0, 65535));
        end
        default: begin
          s = base + 16'($urandom_range(0, 63));
          if ($urandom_range(9) == 0) e = s - 16'($urandom_range(1, 20));
          else e = s + 16'($urandom_range(0, 40));
          if ($urandom_range(1) == 0) w = 16'($urandom_range(0, 65535));
          else w = 16'($urandom_range(0, 255));
        end
      endcase
      send_job(s, e, w, k == n - 1);
    end
  endtask

  initial begin
    int unsigned r;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    drain_done = 1'b0;
    sets_sent  = 0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // single jobs at the field extremes
    send_job(16'd0, 16'd0, 16'd0, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // end below start counts only at its start
    send_job(16'd100, 16'd50, 16'd7, 1'b0);
    send_job(16'd100, 16'd100, 16'd3, 1'b0);
    send_job(16'd101, 16'd200, 16'd5, 1'b1);
    // inclusive end meets a start
    send_job(16'd10, 16'd20, 16'd4, 1'b0);
    send_job(16'd20, 16'd30, 16'd6, 1'b1);
    // disjoint jobs, end wrapped below a maximal start
    send_job(16'd0, 16'd5, 16'd9, 1'b0);
    send_job(16'd6, 16'd9, 16'd8, 1'b0);
    send_job(16'hFFFF, 16'd0, 16'd1, 1'b1);
    // nested, with a zero load
    send_job(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_job(16'd1, 16'd1, 16'd0, 1'b0);
    send_job(16'd2, 16'd3, 16'd1, 1'b1);

    while (items_sent < ITEM_GOAL || sets_sent < SET_GOAL) begin
      if (sets_sent == 12 || $urandom_range(19) == 0) wait_for_results();
      r = $urandom_range(99);
      if (r < 4) send_set(SET_PEAK, N_JOBS);
      else if (r < 8) send_set(SET_FULL, N_JOBS);
      else if (r < 16) send_set(SET_OVER, N_JOBS + $urandom_range(1, 6));
      else if (r < 22) send_set(SET_NOISE, $urandom_range(1, 12));
      else send_set(SET_SHAPED, $urandom_range(1, 12));
    end

    wait_for_results();
    repeat (200) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned n;
    logic        v;
    out_stall      = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_hold_done && res_cnt >= 8) begin
        // long hold-off so the block backs up into its input
        long_hold_done = 1'b1;
        v = 1'b1;
        n = 400;
      end else begin
        r = $urandom_range(99);
        if (r < 55) begin
          v = 1'b0;
          n = $urandom_range(1, 30);
        end else if (r < 92) begin
          v = 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          v = 1'b1;
          n = $urandom_range(15, 60);
        end
      end
      out_stall <= v;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles", $time, idle_cycles);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
